[hw/rtl/rgb_box_blur_valid_defines.svh]
// Assertion macros for the RGB box blur block.
// Set ASSERT_OFF to compile the checks out.
`ifndef RGB_BOX_BLUR_VALID_DEFINES_SVH
`define RGB_BOX_BLUR_VALID_DEFINES_SVH
`ifndef ASSERT_OFF
`define RBB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbb assertion failed");
`define RBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbb assertion failed");
`else
`define RBB_ASSERT_IMPL(lbl, ante, cons)
`define RBB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/rbb_pkg.sv]
// Shared constants and lane control type for the RGB box blur.
// No dependencies.
package rbb_pkg;
  localparam int MAX_KERNEL = 15;
  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_ROWS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int RSLOT_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int LINE_AW    = $clog2(LINE_ROWS * MAX_WIDTH);
  localparam int K_W        = 4;
  localparam int AREA_W     = 2 * K_W;
  localparam int CSUM_W     = 12;
  localparam int WSUM_W     = 16;
  localparam int PIX_W      = 8;
  localparam int BIT_W      = 3;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic               calc;
    logic               k1;
    logic               row0;
    logic               leave;
    logic               col0;
    logic               sub;
    logic               div_step;
    logic [BIT_W-1:0]   div_bit;
    logic [AREA_W-1:0]  area;
    logic [LINE_AW-1:0] line_addr;
    logic [COL_W-1:0]   col_addr;
    logic [RSLOT_W-1:0] rslot;
  } lane_ctl_t;
endpackage

[hw/rtl/rgb_box_blur_valid.sv]
// RGB box blur over valid windows; top level with sequencer and output stage.
// Depends on rbb_pkg, rbb_lane and rgb_box_blur_valid_defines.svh.
//
// Each accepted pixel goes through accept, read and update; when it completes a
// window it then goes through eight divide steps and an output load. The
// per-lane bit-serial divide by k*k makes that path the longer one. A stall on
// the output adds delay only when a new result is ready while the output
// register still holds an unaccepted beat. The next pixel is accepted while
// the previous result waits on the output register. Out of range registers
// are clamped: a kernel or size of 0 acts as 1, a width above 1024 as 1024
// and a height above 4096 as 4096. Writing any known register restarts the
// frame.
`include "rgb_box_blur_valid_defines.svh"
module rgb_box_blur_valid (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_CALC, S_DIV, S_OUT} state_t;

  state_t state_r;
  logic [rbb_pkg::K_W-1:0]     k_r;
  logic [10:0]                 w_r;
  logic [12:0]                 h_r;
  logic [rbb_pkg::COL_W-1:0]   c_r;
  logic [11:0]                 r_r;
  logic [rbb_pkg::SLOT_W-1:0]  slot_r;
  logic [rbb_pkg::RSLOT_W-1:0] rs_r;
  logic [rbb_pkg::BIT_W-1:0]   bit_r;
  logic [7:0]                  pix_r [3];
  logic                        emit_r, last_r;
  logic                        out_valid_r, out_last_r;
  logic [7:0]                  out_q_r [3];
  logic [7:0]                  quot [3];

  logic [rbb_pkg::K_W-1:0]    keff;
  logic [10:0]                weff;
  logic [12:0]                heff;
  logic [rbb_pkg::AREA_W-1:0] area;
  logic                       in_acc, out_free, line_end, cfg_known;
  rbb_pkg::lane_ctl_t         ctl;

  always_comb begin
    keff = (k_r == '0) ? rbb_pkg::K_W'(1) : k_r;
    weff = (w_r == '0) ? 11'd1 : ((w_r > 11'(rbb_pkg::MAX_WIDTH)) ?
           11'(rbb_pkg::MAX_WIDTH) : w_r);
    heff = (h_r == '0) ? 13'd1 : ((h_r > 13'd4096) ? 13'd4096 : h_r);
    area = rbb_pkg::AREA_W'(keff) * rbb_pkg::AREA_W'(keff);
    in_acc   = in_valid && (state_r == S_IDLE);
    out_free = !out_valid_r || !out_stall;
    line_end = (11'(c_r) + 11'd1) >= weff;
    cfg_known = cfg_we && (cfg_index == rbb_pkg::REG_KERNEL ||
                cfg_index == rbb_pkg::REG_WIDTH || cfg_index == rbb_pkg::REG_HEIGHT);
    ctl.calc      = (state_r == S_CALC);
    ctl.k1        = (keff == rbb_pkg::K_W'(1));
    ctl.row0      = (r_r == '0);
    ctl.leave     = r_r >= (12'(keff) - 12'd1);
    ctl.col0      = (c_r == '0);
    ctl.sub       = 11'(c_r) >= 11'(keff);
    ctl.div_step  = (state_r == S_DIV);
    ctl.div_bit   = bit_r;
    ctl.area      = area;
    ctl.line_addr = rbb_pkg::LINE_AW'(slot_r) * rbb_pkg::LINE_AW'(rbb_pkg::MAX_WIDTH)
                    + rbb_pkg::LINE_AW'(c_r);
    ctl.col_addr  = c_r;
    ctl.rslot     = rs_r;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rbb_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .pix  (pix_r[g]),
      .quot (quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 4'd3;
      w_r         <= 11'd640;
      h_r         <= 13'd480;
      c_r         <= '0;
      r_r         <= '0;
      slot_r      <= '0;
      rs_r        <= '0;
      bit_r       <= '0;
      emit_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rbb_pkg::REG_KERNEL: k_r <= cfg_wdata[3:0];
          rbb_pkg::REG_WIDTH:  w_r <= cfg_wdata[10:0];
          rbb_pkg::REG_HEIGHT: h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_known) begin
        c_r    <= '0;
        r_r    <= '0;
        slot_r <= '0;
        rs_r   <= '0;
      end else if (state_r == S_CALC) begin
        if (line_end) begin
          c_r  <= '0;
          rs_r <= '0;
          if ((13'(r_r) + 13'd1) >= heff) begin
            r_r    <= '0;
            slot_r <= '0;
          end else begin
            r_r    <= r_r + 12'd1;
            slot_r <= ((slot_r + 1'b1) == rbb_pkg::SLOT_W'(keff - 1'b1)) ?
                      '0 : slot_r + 1'b1;
          end
        end else begin
          c_r  <= c_r + 1'b1;
          rs_r <= ((rs_r + 1'b1) == rbb_pkg::RSLOT_W'(keff)) ? '0 : rs_r + 1'b1;
        end
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        out_last_r  <= last_r;
        out_q_r     <= quot;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pix_r[0] <= in_red;
            pix_r[1] <= in_green;
            pix_r[2] <= in_blue;
            state_r  <= S_RD;
          end
        end
        S_RD: state_r <= S_CALC;
        S_CALC: begin
          emit_r <= ((13'(r_r) + 13'd1) >= 13'(keff)) &&
                    ((11'(c_r) + 11'd1) >= 11'(keff));
          last_r <= ((13'(r_r) + 13'd1) == heff) && ((11'(c_r) + 11'd1) == weff);
          bit_r  <= rbb_pkg::BIT_W'(7);
          state_r <= ((13'(r_r) + 13'd1) >= 13'(keff) &&
                     (11'(c_r) + 11'd1) >= 11'(keff)) ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          bit_r <= bit_r - 1'b1;
          if (bit_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_red        = out_q_r[0];
  assign out_green      = out_q_r[1];
  assign out_blue       = out_q_r[2];
  assign out_frame_last = out_last_r;

  `RBB_ASSERT_NEXT(a_acc_rd, in_valid && !in_stall, state_r == S_RD)
  `RBB_ASSERT_NEXT(a_div_ok, state_r == S_DIV, state_r == S_DIV || state_r == S_OUT)
  `RBB_ASSERT_IMPL(a_emit, state_r == S_DIV, emit_r)
endmodule

[hw/rtl/rbb_lane.sv]
// One color lane: line store, column sums, recent column sums, window sum
// and bit-serial divide by the kernel area. Depends on rbb_pkg.
module rbb_lane (
  input  logic                      clk,
  input  rbb_pkg::lane_ctl_t        ctl,
  input  logic [rbb_pkg::PIX_W-1:0] pix,
  output logic [rbb_pkg::PIX_W-1:0] quot
);
  logic [rbb_pkg::PIX_W-1:0]  line_mem [rbb_pkg::LINE_ROWS*rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::CSUM_W-1:0] col_mem  [rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::CSUM_W-1:0] rec_mem  [rbb_pkg::MAX_KERNEL];

  logic [rbb_pkg::PIX_W-1:0]  line_q_r;
  logic [rbb_pkg::CSUM_W-1:0] col_q_r;
  logic [rbb_pkg::CSUM_W-1:0] rec_q_r;
  logic [rbb_pkg::WSUM_W-1:0] ws_r, ws_nxt;
  logic [rbb_pkg::WSUM_W-1:0] rem_r;
  logic [rbb_pkg::PIX_W-1:0]  q_r;
  logic [rbb_pkg::CSUM_W-1:0] full, prior, leaving;
  logic [rbb_pkg::WSUM_W-1:0] trial;

  always_comb begin
    prior   = ctl.row0 ? '0 : col_q_r;
    full    = ctl.k1 ? rbb_pkg::CSUM_W'(pix) : prior + rbb_pkg::CSUM_W'(pix);
    leaving = ctl.leave ? rbb_pkg::CSUM_W'(line_q_r) : '0;
    ws_nxt  = (ctl.col0 ? '0 : ws_r) + rbb_pkg::WSUM_W'(full)
              - (ctl.sub ? rbb_pkg::WSUM_W'(rec_q_r) : '0);
    trial   = rbb_pkg::WSUM_W'(ctl.area) << ctl.div_bit;
  end

  always_ff @(posedge clk) begin
    line_q_r <= line_mem[ctl.line_addr];
    col_q_r  <= col_mem[ctl.col_addr];
    rec_q_r  <= rec_mem[ctl.rslot];
    if (ctl.calc) begin
      if (!ctl.k1) begin
        line_mem[ctl.line_addr] <= pix;
        col_mem[ctl.col_addr]   <= full - leaving;
      end
      rec_mem[ctl.rslot] <= full;
      ws_r  <= ws_nxt;
      rem_r <= ws_nxt;
      q_r   <= '0;
    end else if (ctl.div_step) begin
      if (rem_r >= trial) begin
        rem_r            <= rem_r - trial;
        q_r[ctl.div_bit] <= 1'b1;
      end
    end
  end

  assign quot = q_r;
endmodule

[bench/tb_rgb_box_blur_valid.sv]
// Self-checking bench for the RGB box blur: drives pixel frames, register
// writes and stalls, and predicts every averaged pixel with a scoreboard class.
// Depends on rbb_pkg and the rgb_box_blur_valid RTL.
module tb_rgb_box_blur_valid;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_pix_t;

  class blur_scoreboard;
    int unsigned kern, wid, hgt;
    int unsigned lines [rbb_pkg::LINE_ROWS][rbb_pkg::MAX_WIDTH];
    int unsigned col_sum [rbb_pkg::MAX_WIDTH][3];
    int unsigned recent [rbb_pkg::MAX_KERNEL][3];
    int unsigned win_sum [3];
    int unsigned col, row;
    blur_pix_t   averages_q[$];
    int          errors;

    function void restart();
      win_sum = '{0, 0, 0};
      col = 0;
      row = 0;
    endfunction

    function void reset();
      kern = 3;
      wid = 640;
      hgt = 480;
      averages_q.delete();
      errors = 0;
      restart();
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        rbb_pkg::REG_KERNEL: kern = 32'(val[3:0]);
        rbb_pkg::REG_WIDTH:  wid = 32'(val[10:0]);
        rbb_pkg::REG_HEIGHT: hgt = 32'(val);
        default:    return;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned k, w, h, c, rw, slot, old, leaving, prior, rs;
      int unsigned pix [3];
      int unsigned full [3];
      blur_pix_t e;
      k = clamp(kern, rbb_pkg::MAX_KERNEL);
      w = clamp(wid, rbb_pkg::MAX_WIDTH);
      h = clamp(hgt, 4096);
      c = (col >= w) ? 0 : col;
      rw = (row >= h) ? 0 : row;
      pix = '{32'(r), 32'(g), 32'(b)};
      if (k == 1) begin
        full = pix;
      end else begin
        slot = rw % (k - 1);
        old = lines[slot][c];
        for (int ch = 0; ch < 3; ch++) begin
          prior = (rw == 0) ? 0 : col_sum[c][ch];
          leaving = (rw >= k - 1) ? ((old >> (8 * ch)) & 8'hFF) : 0;
          full[ch] = prior + pix[ch];
          col_sum[c][ch] = (full[ch] - leaving) & 16'hFFFF;
        end
        lines[slot][c] = pix[0] | (pix[1] << 8) | (pix[2] << 16);
      end
      rs = c % k;
      for (int ch = 0; ch < 3; ch++) begin
        if (c == 0) win_sum[ch] = 0;
        win_sum[ch] += full[ch];
        if (c >= k) win_sum[ch] -= recent[rs][ch];
        recent[rs][ch] = full[ch] & 16'hFFFF;
      end
      if (rw + 1 >= k && c + 1 >= k) begin
        e.red = 8'(win_sum[0] / (k * k));
        e.green = 8'(win_sum[1] / (k * k));
        e.blue = 8'(win_sum[2] / (k * k));
        e.last = (rw + 1 == h && c + 1 == w);
        averages_q.push_back(e);
      end
      if (c + 1 >= w) begin
        col = 0;
        row = (rw + 1 >= h) ? 0 : rw + 1;
      end else begin
        col = c + 1;
        row = rw;
      end
    endfunction

    function void check_average(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic l);
      blur_pix_t e;
      if (averages_q.size() == 0) begin
        $error("unexpected output beat red=%0d green=%0d blue=%0d", r, g, b);
        errors++;
        return;
      end
      e = averages_q.pop_front();
      if (r !== e.red) begin
        $error("red_out expected %0d actual %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("green_out expected %0d actual %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("blue_out expected %0d actual %0d", e.blue, b);
        errors++;
      end
      if (l !== e.last) begin
        $error("frame_last expected %0d actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_frame_last;

  blur_scoreboard sb = new();
  int burst_left = 0;
  int sent = 0;
  int stall_mode = 0;
  bit pix_extreme = 0;

  rgb_box_blur_valid i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.note_pixel(in_red, in_green, in_blue);
      if (out_valid && !out_stall)
        sb.check_average(out_red, out_green, out_blue, out_frame_last);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ($urandom_range(0, 31) == 0) ? ~out_stall : out_stall;
    endcase
  end

  function automatic logic [7:0] pick_level();
    if (pix_extreme || $urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.averages_q.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_frame(logic [12:0] k, logic [12:0] w, logic [12:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= rbb_pkg::REG_KERNEL;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_index <= rbb_pkg::REG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= rbb_pkg::REG_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_run(int n);
    for (int i = 0; i < n; i++) send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  initial begin
    int sel, k, w, h, n, big;
    sb.reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, partial line
    send_run(3);
    pix_extreme = 1;
    set_frame(13'd0, 13'd3, 13'd1);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hA5, 8'h5A, 8'h3C);
    set_frame(13'd2, 13'd2, 13'd2);
    repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
    set_frame(13'd3, 13'd2, 13'd4);
    send_run(4);
    set_frame(13'd15, 13'd0, 13'd0);
    send_run(2);
    set_frame(13'd1, 13'd2047, 13'd8191);
    send_run(5);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_wdata <= 13'h1FFF;
    @(negedge clk);
    cfg_we <= 1'b0;
    send_run(3);

    big = 0;
    while (sent < 1120) begin
      pix_extreme = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0 && big < 2) begin
        big++;
        k = 15;
        w = 15 + $urandom_range(0, 3);
        h = 15;
        n = w * h;
      end else if (sel <= 1) begin
        k = $urandom_range(0, 15);
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 8191);
        n = $urandom_range(1, 40);
      end else begin
        k = $urandom_range(1, 6);
        w = $urandom_range(1, 14);
        h = $urandom_range(1, 8);
        n = w * h * $urandom_range(1, 2) + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0);
      end
      set_frame(13'(k), 13'(w), 13'(h));
      send_run(n / 2);
      if (sel == 2) drain();
      send_run(n - n / 2);
    end

    drain();
    if (sb.errors == 0 && sb.averages_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rbb_pkg.sv
hw/rtl/rbb_lane.sv
hw/rtl/rgb_box_blur_valid.sv
bench/tb_rgb_box_blur_valid.sv
